/* rtl/ssc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned DRIVE_W   = SPEED_W + 1;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN   = 3'd5;

  localparam logic signed [ANGLE_W-1:0] RST_MIN_ANGLE  = -16'sd12868;
  localparam logic signed [ANGLE_W-1:0] RST_MAX_ANGLE  = 16'sd12868;
  localparam logic [ANGLE_W-1:0]        RST_ANGLE_STEP = 16'd819;
  localparam logic [SPEED_W-1:0]        RST_DRV_SPEED  = 8'd100;
  localparam logic [AGE_W-1:0]          RST_STUCK      = 16'd5;
  localparam logic [AGE_W-1:0]          RST_COOLDOWN   = 16'd25;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_lo;
    logic signed [ANGLE_W-1:0] angle_hi;
    logic [ANGLE_W-1:0]        angle_step;
    logic [SPEED_W-1:0]        drive_speed;
    logic [AGE_W-1:0]          stuck_ticks;
    logic [AGE_W-1:0]          cooldown_ticks;
  } ssc_cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] position;
    logic [STEP_W-1:0]         step_count;
    logic [DIST_W-1:0]         distance;
  } ssc_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sample_valid;
    logic signed [ANGLE_W-1:0] sample_angle;
    logic [DIST_W-1:0]         sample_distance;
    logic                      sweep_end;
  } ssc_result_t;

endpackage

`default_nettype wire

/* rtl/ssc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssc_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              wr_en_i,
  input  wire logic [ssc_pkg::CFG_IDX_W-1:0]     wr_index_i,
  input  wire logic [ssc_pkg::CFG_DAT_W-1:0]     wr_data_i,
  output ssc_pkg::ssc_cfg_t                      cfg_o
);

  ssc_pkg::ssc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        ssc_pkg::REG_MIN_ANGLE:  cfg_d.angle_lo       = wr_data_i;
        ssc_pkg::REG_MAX_ANGLE:  cfg_d.angle_hi       = wr_data_i;
        ssc_pkg::REG_ANGLE_STEP: cfg_d.angle_step     = wr_data_i;
        ssc_pkg::REG_DRV_SPEED:  cfg_d.drive_speed    = wr_data_i[ssc_pkg::SPEED_W-1:0];
        ssc_pkg::REG_STUCK:      cfg_d.stuck_ticks    = wr_data_i;
        ssc_pkg::REG_COOLDOWN:   cfg_d.cooldown_ticks = wr_data_i;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_lo       <= ssc_pkg::RST_MIN_ANGLE;
      cfg_q.angle_hi       <= ssc_pkg::RST_MAX_ANGLE;
      cfg_q.angle_step     <= ssc_pkg::RST_ANGLE_STEP;
      cfg_q.drive_speed    <= ssc_pkg::RST_DRV_SPEED;
      cfg_q.stuck_ticks    <= ssc_pkg::RST_STUCK;
      cfg_q.cooldown_ticks <= ssc_pkg::RST_COOLDOWN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/ssc_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssc_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 advance_i,
  input  wire ssc_pkg::ssc_cfg_t    cfg_i,
  input  wire ssc_pkg::ssc_item_t   item_i,
  output ssc_pkg::ssc_result_t      result_o
);

  logic                                forward_q, forward_d;
  logic                                sampling_q, sampling_d;
  logic [ssc_pkg::STEP_W-1:0]          last_step_q, last_step_d;
  logic [ssc_pkg::AGE_W-1:0]           move_age_q, move_age_d;
  logic [ssc_pkg::AGE_W-1:0]           restart_age_q, restart_age_d;
  logic signed [ssc_pkg::ANGLE_W-1:0]  last_pos_q, last_pos_d;
  logic                                have_pos_q, have_pos_d;
  logic                                sweep_has_q, sweep_has_d;

  logic [ssc_pkg::AGE_W-1:0]           restart_inc;
  logic                                stalled, restart, reverse, take;
  logic signed [ssc_pkg::ANGLE_W:0]    diff;
  logic [ssc_pkg::ANGLE_W:0]           abs_diff;
  logic signed [ssc_pkg::DRIVE_W-1:0]  speed_ext;

  always_comb begin
    // saturating tick ages; a step change restarts the move age
    restart_inc = (restart_age_q == ssc_pkg::AGE_MAX) ? restart_age_q
                                                      : restart_age_q + 1'b1;
    last_step_d = item_i.step_count;
    if (item_i.step_count != last_step_q) begin
      move_age_d = '0;
    end else begin
      move_age_d = (move_age_q == ssc_pkg::AGE_MAX) ? move_age_q : move_age_q + 1'b1;
    end

    stalled = (move_age_d > cfg_i.stuck_ticks) && (restart_inc > cfg_i.cooldown_ticks)
              && (cfg_i.drive_speed != '0);

    restart = (item_i.position < cfg_i.angle_lo) || (stalled && !forward_q);
    reverse = !restart && ((item_i.position > cfg_i.angle_hi) || (stalled && forward_q));

    forward_d     = forward_q;
    sampling_d    = sampling_q;
    restart_age_d = restart_inc;
    sweep_has_d   = sweep_has_q;
    if (restart) begin
      forward_d     = 1'b1;
      sampling_d    = 1'b1;
      restart_age_d = '0;
    end else if (reverse) begin
      forward_d   = 1'b0;
      sampling_d  = 1'b0;
      sweep_has_d = 1'b0;
    end

    diff     = {item_i.position[ssc_pkg::ANGLE_W-1], item_i.position}
             - {last_pos_q[ssc_pkg::ANGLE_W-1], last_pos_q};
    abs_diff = diff[ssc_pkg::ANGLE_W] ? -diff : diff;
    take     = sampling_d && (!have_pos_q || (abs_diff > {1'b0, cfg_i.angle_step}));

    last_pos_d = last_pos_q;
    have_pos_d = have_pos_q;
    if (take) begin
      last_pos_d  = item_i.position;
      have_pos_d  = 1'b1;
      sweep_has_d = 1'b1;
    end

    speed_ext = {1'b0, cfg_i.drive_speed};
    result_o.drive           = forward_d ? speed_ext : -speed_ext;
    result_o.sample_valid    = take;
    result_o.sample_angle    = take ? item_i.position : '0;
    result_o.sample_distance = take ? item_i.distance : '0;
    result_o.sweep_end       = reverse && sweep_has_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_q     <= 1'b1;
      sampling_q    <= 1'b0;
      last_step_q   <= '0;
      move_age_q    <= '0;
      restart_age_q <= '0;
      last_pos_q    <= '0;
      have_pos_q    <= 1'b0;
      sweep_has_q   <= 1'b0;
    end else if (advance_i) begin
      forward_q     <= forward_d;
      sampling_q    <= sampling_d;
      last_step_q   <= last_step_d;
      move_age_q    <= move_age_d;
      restart_age_q <= restart_age_d;
      last_pos_q    <= last_pos_d;
      have_pos_q    <= have_pos_d;
      sweep_has_q   <= sweep_has_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/scan_sweep_controller_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Oscillating scan controller: one request per sensor tick carries position,
// step_count and distance; exactly one result comes back per request with the
// motor drive command, an optional sample and the sweep_end flag.
// Channels: input (in_valid_i / in_stall_o) and output (out_valid_o /
// out_stall_i) move a request when valid is high and stall is low. The
// configuration port (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) is
// always ready; write it only while no request is in flight.
// Path: a taken request sits in the input register, is evaluated and moves
// into the result register, which drives out_valid_o. Throughput: one request
// per cycle while out_stall_i is low, set by the single evaluation stage
// between the input and result registers.
// Stall: when out_stall_i holds a result, the input register keeps its request
// and in_stall_o rises only if that register is full; the sweep state advances
// only when a request moves into the result register.
// Reset: both registers empty, sweep state forward with sampling off, all
// ages and markers zero, configuration registers at their defaults.
module scan_sweep_controller_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic signed [ssc_pkg::ANGLE_W-1:0]   position_i,
  input  wire logic [ssc_pkg::STEP_W-1:0]           step_count_i,
  input  wire logic [ssc_pkg::DIST_W-1:0]           distance_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic signed [ssc_pkg::DRIVE_W-1:0]   drive_o,
  output      logic                                 sample_valid_o,
  output      logic signed [ssc_pkg::ANGLE_W-1:0]   sample_angle_o,
  output      logic [ssc_pkg::DIST_W-1:0]           sample_distance_o,
  output      logic                                 sweep_end_o,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [ssc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [ssc_pkg::CFG_DAT_W-1:0]        cfg_data_i
);

  ssc_pkg::ssc_cfg_t    cfg;
  ssc_pkg::ssc_item_t   item_q, item_d;
  ssc_pkg::ssc_result_t res, res_q;
  logic                 item_vld_q, item_vld_d;
  logic                 out_vld_q, out_vld_d;
  logic                 in_take, advance;

  assign cfg_ready_o = 1'b1;

  ssc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // advance the held request whenever the result register is free or draining
  assign advance    = item_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = item_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.position   = position_i;
    item_d.step_count = step_count_i;
    item_d.distance   = distance_i;
    item_vld_d        = in_take || (item_vld_q && !advance);
    out_vld_d         = advance || (out_vld_q && out_stall_i);
  end

  ssc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers: load the input on take, the result on advance
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign drive_o           = res_q.drive;
  assign sample_valid_o    = res_q.sample_valid;
  assign sample_angle_o    = res_q.sample_angle;
  assign sample_distance_o = res_q.sample_distance;
  assign sweep_end_o       = res_q.sweep_end;

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_TICKS = 133;
  localparam int NUM_DIRECTED = 21;

  // directed sweep: limits, exact thresholds and out-of-range angle patterns
  localparam int DIR_POS [NUM_DIRECTED] = '{
    0, -25736, -25000, -24917, -24916, 25735, 25735, 0, -12869, -32768,
    32767, 32767, -12868, -12869, 12868, 12869, -12869, 12869, 12869, -13000, 0};
  localparam int DIR_STEP [NUM_DIRECTED] = '{
    0, 1, 2, 3, 4, 5, 5, 6, 7, 65535,
    0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 8};

  // Sweep predictor and store of expected tick results, in request order.
  class sweep_scoreboard;
    logic signed [ssc_pkg::ANGLE_W-1:0] min_ang, max_ang, last_pos;
    logic [ssc_pkg::ANGLE_W-1:0]        step_thr;
    logic [ssc_pkg::SPEED_W-1:0]        speed;
    logic [ssc_pkg::AGE_W-1:0]          stuck_lim, cool_lim, move_age, restart_age;
    logic [ssc_pkg::STEP_W-1:0]         prev_step;
    bit                                 fwd, sampling, have_pos, has_samples;
    ssc_pkg::ssc_result_t               expected_q[$];
    int                                 errors;

    function new();
      min_ang     = ssc_pkg::RST_MIN_ANGLE;
      max_ang     = ssc_pkg::RST_MAX_ANGLE;
      step_thr    = ssc_pkg::RST_ANGLE_STEP;
      speed       = ssc_pkg::RST_DRV_SPEED;
      stuck_lim   = ssc_pkg::RST_STUCK;
      cool_lim    = ssc_pkg::RST_COOLDOWN;
      fwd         = 1'b1;
      sampling    = 1'b0;
      have_pos    = 1'b0;
      has_samples = 1'b0;
      prev_step   = '0;
      move_age    = '0;
      restart_age = '0;
      last_pos    = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [ssc_pkg::CFG_IDX_W-1:0] idx,
                            logic [ssc_pkg::CFG_DAT_W-1:0] data);
      case (idx)
        ssc_pkg::REG_MIN_ANGLE:  min_ang   = data;
        ssc_pkg::REG_MAX_ANGLE:  max_ang   = data;
        ssc_pkg::REG_ANGLE_STEP: step_thr  = data;
        ssc_pkg::REG_DRV_SPEED:  speed     = data[ssc_pkg::SPEED_W-1:0];
        ssc_pkg::REG_STUCK:      stuck_lim = data;
        ssc_pkg::REG_COOLDOWN:   cool_lim  = data;
        default: ;
      endcase
    endfunction

    // Advance the sweep state by one tick and queue the result it yields.
    function void note_request(ssc_pkg::ssc_item_t it);
      ssc_pkg::ssc_result_t        r;
      logic [ssc_pkg::DRIVE_W-1:0] mag;
      bit                          stalled;
      int                          diff;
      int                          thr;
      r = '0;
      if (move_age != ssc_pkg::AGE_MAX) move_age = move_age + 1'b1;
      if (restart_age != ssc_pkg::AGE_MAX) restart_age = restart_age + 1'b1;
      if (it.step_count != prev_step) begin
        move_age  = '0;
        prev_step = it.step_count;
      end
      stalled = (move_age > stuck_lim) && (restart_age > cool_lim) && (speed != '0);
      if ((it.position < min_ang) || (stalled && !fwd)) begin
        fwd         = 1'b1;
        sampling    = 1'b1;
        restart_age = '0;
      end else if ((it.position > max_ang) || (stalled && fwd)) begin
        fwd         = 1'b0;
        sampling    = 1'b0;
        r.sweep_end = has_samples;
        has_samples = 1'b0;
      end
      if (sampling) begin
        diff = $signed(it.position) - $signed(last_pos);
        if (diff < 0) diff = -diff;
        thr = step_thr;
        if (!have_pos || diff > thr) begin
          r.sample_valid    = 1'b1;
          r.sample_angle    = it.position;
          r.sample_distance = it.distance;
          last_pos          = it.position;
          have_pos          = 1'b1;
          has_samples       = 1'b1;
        end
      end
      mag = {1'b0, speed};
      r.drive = fwd ? mag : -mag;
      expected_q = {expected_q, r};
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_result(ssc_pkg::ssc_result_t got);
      ssc_pkg::ssc_result_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch("tick result with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.drive !== want.drive)
        flag_mismatch($sformatf("drive %0d, want %0d", got.drive, want.drive));
      if (got.sample_valid !== want.sample_valid)
        flag_mismatch($sformatf("sample_valid %b, want %b",
                                got.sample_valid, want.sample_valid));
      if (got.sample_angle !== want.sample_angle)
        flag_mismatch($sformatf("sample_angle %0d, want %0d",
                                got.sample_angle, want.sample_angle));
      if (got.sample_distance !== want.sample_distance)
        flag_mismatch($sformatf("sample_distance %0d, want %0d",
                                got.sample_distance, want.sample_distance));
      if (got.sweep_end !== want.sweep_end)
        flag_mismatch($sformatf("sweep_end %b, want %b", got.sweep_end, want.sweep_end));
    endtask
  endclass

  logic                               clk;
  logic                               rst_n      = 1'b0;
  logic                               in_valid   = 1'b0;
  logic                               in_stall;
  logic signed [ssc_pkg::ANGLE_W-1:0] position   = '0;
  logic [ssc_pkg::STEP_W-1:0]         step_count = '0;
  logic [ssc_pkg::DIST_W-1:0]         distance   = '0;
  logic                               out_valid;
  logic                               out_stall  = 1'b0;
  logic signed [ssc_pkg::DRIVE_W-1:0] drive;
  logic                               sample_valid;
  logic signed [ssc_pkg::ANGLE_W-1:0] sample_angle;
  logic [ssc_pkg::DIST_W-1:0]         sample_distance;
  logic                               sweep_end;
  logic                               cfg_valid  = 1'b0;
  logic                               cfg_ready;
  logic [ssc_pkg::CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [ssc_pkg::CFG_DAT_W-1:0]      cfg_data   = '0;

  sweep_scoreboard sb = new();

  int          cycles    = 0;
  int          rx_hold   = 0;
  bit          tx_calm   = 1'b0;
  bit          rx_calm   = 1'b0;
  // virtual pivot that follows the predicted motor direction
  int          pivot     = 0;
  logic [15:0] enc_step  = '0;
  int          jam_left  = 0;

  scan_sweep_controller_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .position_i        (position),
    .step_count_i      (step_count),
    .distance_i        (distance),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .drive_o           (drive),
    .sample_valid_o    (sample_valid),
    .sample_angle_o    (sample_angle),
    .sample_distance_o (sample_distance),
    .sweep_end_o       (sweep_end),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample results at the rising edge; bound the run with a cycle count.
  always @(posedge clk) begin
    ssc_pkg::ssc_result_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
    if (out_valid && !out_stall) begin
      got.drive           = drive;
      got.sample_valid    = sample_valid;
      got.sample_angle    = sample_angle;
      got.sample_distance = sample_distance;
      got.sweep_end       = sweep_end;
      sb.check_result(got);
      // draw how long to hold off the next result
      rx_hold = rx_calm ? 0 : $urandom_range(0, 12);
    end
  end

  // Hold stall for the drawn number of cycles, then release it.
  always @(negedge clk) begin
    out_stall <= (rx_hold > 0);
    if (rx_hold > 0) rx_hold--;
  end

  // Present one request after an idle gap and wait for it to be taken.
  // Enter and leave at a falling edge; valid stays high on return.
  task automatic send_tick(input ssc_pkg::ssc_item_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    position   <= it.position;
    step_count <= it.step_count;
    distance   <= it.distance;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_cfg(input logic [ssc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ssc_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Write all registers for one phase: extremes, crossed limits, zero drive,
  // then random settings.
  task automatic load_config(input int ph);
    logic [ssc_pkg::CFG_DAT_W-1:0] vals [6];
    logic [ssc_pkg::CFG_IDX_W-1:0] regs [6];
    regs = '{ssc_pkg::REG_MIN_ANGLE, ssc_pkg::REG_MAX_ANGLE, ssc_pkg::REG_ANGLE_STEP,
             ssc_pkg::REG_DRV_SPEED, ssc_pkg::REG_STUCK, ssc_pkg::REG_COOLDOWN};
    vals[0] = 16'(-$urandom_range(25736, 500));
    vals[1] = 16'($urandom_range(500, 25735));
    vals[2] = 16'($urandom_range(0, 2000));
    vals[3] = {8'($urandom), 8'($urandom_range(1, 255))};
    vals[4] = 16'($urandom_range(0, 40));
    vals[5] = 16'($urandom_range(0, 60));
    case (ph)
      1: vals = '{-16'sd25736, 16'sd25735, 16'd0, 16'd255, 16'd0, 16'd0};
      2: vals = '{16'h8000, 16'h7fff, 16'hffff, 16'd1, 16'hffff, 16'hffff};
      3: begin
        vals[0] = 16'sd2000;
        vals[1] = -16'sd2000;
      end
      4: vals[3] = 16'd0;
      default: ;
    endcase
    for (int i = 0; i < 6; i++) write_cfg(regs[i], vals[i]);
  endtask

  // Next tick of the virtual pivot: mostly smooth motion toward the current
  // limit, with encoder jams that provoke stalls and some raw noise.
  function automatic void make_tick(output ssc_pkg::ssc_item_t it);
    int delta;
    it.distance = 16'($urandom);
    if ($urandom_range(0, 99) < 12) begin
      it.position   = 16'($urandom);
      it.step_count = 16'($urandom);
      return;
    end
    if (jam_left == 0 && $urandom_range(0, 39) == 0) jam_left = $urandom_range(1, 45);
    if (jam_left > 0) begin
      jam_left--;
      delta = 0;
    end else begin
      delta = $urandom_range(0, 1200);
      if ($urandom_range(0, 7) == 0) delta = $urandom_range(0, 6000);
      if (delta != 0) enc_step++;
      if ($urandom_range(0, 63) == 0) enc_step = 16'($urandom);
    end
    pivot = sb.fwd ? pivot + delta : pivot - delta;
    if (pivot > 32767) pivot = 32767;
    if (pivot < -32768) pivot = -32768;
    it.position   = pivot[15:0];
    it.step_count = enc_step;
  endfunction

  initial begin
    ssc_pkg::ssc_item_t it;
    int                 gap;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sweep with the reset configuration
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      it.position   = 16'(DIR_POS[i]);
      it.step_count = 16'(DIR_STEP[i]);
      it.distance   = (i % 3 == 0) ? 16'd0 : (i % 3 == 1) ? 16'hffff : 16'($urandom);
      send_tick(it, i % 2);
    end

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain();
      load_config(ph);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (n % 45 == 0) begin
          tx_calm = ($urandom_range(0, 2) == 0);
          rx_calm = ($urandom_range(0, 2) == 0);
        end
        // hold off the sender until the result queue runs dry
        if (n == 70 && ph % 2 == 1) drain();
        make_tick(it);
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        send_tick(it, gap);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
